FILE: rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// SSIM window metric package
// Shared types, field layouts and fixed constants of the SSIM window metric.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

	// Fixed SSIM constants for a window of 64 pixels.
	localparam int          K_C1       = 26634;
	localparam int          K_C2       = 239708;
	localparam int          WIN_PIXELS = 64;
	localparam int          K_SHIFT    = 12;
	localparam logic [31:0] C1 = 32'((64'(K_C1) * WIN_PIXELS * WIN_PIXELS) >> K_SHIFT);
	localparam logic [31:0] C2 = 32'((64'(K_C2) * WIN_PIXELS * WIN_PIXELS) >> K_SHIFT);

	// Width of the shared divisor and of the partial remainder.
	localparam int DIV_W = 61;

	// Register indexes on the configuration port (address bit 2).
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] src_pixel;
		logic [7:0] ref_pixel;
	} swm_pixel_t;

	typedef struct packed {
		logic               is_frame_mean;
		logic [11:0]        window_x;
		logic [11:0]        window_y;
		logic signed [17:0] ssim_value;
		logic [19:0]        windows_so_far;
		logic               last_of_item;
	} swm_result_t;

	// One 4x4 block: r in [23:12], s in [11:0]; s*r in [59:40], r*r in [39:20],
	// s*s in [19:0].
	typedef struct packed {
		logic [23:0] pixel_sums;
		logic [59:0] square_sums;
	} swm_block_t;

	// Sums over one 8x8 window.
	typedef struct packed {
		logic [13:0] s;
		logic [13:0] r;
		logic [21:0] ss;
		logic [21:0] rr;
		logic [21:0] sr;
	} swm_sums_t;

	// Numerator magnitude and denominator of one window, ready for division.
	typedef struct packed {
		logic             neg;
		logic             bad;
		logic [62:0]      mag;
		logic [DIV_W-1:0] den;
	} swm_ratio_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_GATHER,
		ST_CALC,
		ST_DIV,
		ST_WIN_OUT,
		ST_MEAN_START,
		ST_MEAN_DIV,
		ST_MEAN_OUT
	} swm_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/swm_block_store.sv
// ----------------------------------------------------------------------------
// SSIM block sum store
// Current and previous block-row sums in two memories, with the update of one block.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_block_store import swm_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          upd_en,
	input  wire logic          upd_first,
	input  wire logic [AW-1:0] upd_addr,
	input  wire swm_pixel_t    pix,
	output swm_block_t         cur_rdata,
	output swm_block_t         prev_rdata,
	output swm_block_t         cur_new
);

	swm_block_t cur_mem  [DEPTH];
	swm_block_t prev_mem [DEPTH];

	logic [15:0] sq_s, sq_r, sq_x;

	assign sq_s = 16'(pix.src_pixel) * 16'(pix.src_pixel);
	assign sq_r = 16'(pix.ref_pixel) * 16'(pix.ref_pixel);
	assign sq_x = 16'(pix.src_pixel) * 16'(pix.ref_pixel);

	// The block's first pixel starts fresh sums; every other pixel adds to them.
	always_comb begin
		if (upd_first) begin
			cur_new.pixel_sums  = {4'd0, pix.ref_pixel, 4'd0, pix.src_pixel};
			cur_new.square_sums = {4'd0, sq_x, 4'd0, sq_r, 4'd0, sq_s};
		end else begin
			cur_new.pixel_sums[11:0]  = cur_rdata.pixel_sums[11:0] + 12'(pix.src_pixel);
			cur_new.pixel_sums[23:12] = cur_rdata.pixel_sums[23:12] + 12'(pix.ref_pixel);
			cur_new.square_sums[19:0]  = cur_rdata.square_sums[19:0] + 20'(sq_s);
			cur_new.square_sums[39:20] = cur_rdata.square_sums[39:20] + 20'(sq_r);
			cur_new.square_sums[59:40] = cur_rdata.square_sums[59:40] + 20'(sq_x);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			cur_rdata  <= cur_mem[rd_addr];
			prev_rdata <= prev_mem[rd_addr];
		end
		if (upd_en) begin
			cur_mem[upd_addr] <= cur_new;
			if (upd_first) begin
				prev_mem[upd_addr] <= cur_rdata;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/swm_window_calc.sv
// ----------------------------------------------------------------------------
// SSIM window arithmetic
// Four-stage pipeline from window sums to numerator magnitude and denominator.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_window_calc import swm_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire swm_sums_t sums,
	output logic           done,
	output swm_ratio_t     ratio
);

	logic [3:0] v_q;

	swm_sums_t          sums_s1;
	logic [27:0]        sr_p_s1, ss_p_s1, rr_p_s1;
	logic signed [31:0] num1_s2, num2_s2, den1_s2, den2_s2;
	logic signed [63:0] num_s3, den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[2:0], start};
		end
	end

	always_ff @(posedge clk) begin
		sums_s1 <= sums;
		sr_p_s1 <= 28'(sums.s) * 28'(sums.r);
		ss_p_s1 <= 28'(sums.s) * 28'(sums.s);
		rr_p_s1 <= 28'(sums.r) * 28'(sums.r);

		num1_s2 <= 32'({sr_p_s1, 1'b0}) + C1;
		num2_s2 <= 32'({sums_s1.sr, 7'd0}) - 32'({sr_p_s1, 1'b0}) + C2;
		den1_s2 <= 32'(ss_p_s1) + 32'(rr_p_s1) + C1;
		den2_s2 <= 32'({sums_s1.ss, 6'd0}) + 32'({sums_s1.rr, 6'd0})
			- 32'(ss_p_s1) - 32'(rr_p_s1) + C2;

		num_s3 <= num1_s2 * num2_s2;
		den_s3 <= den1_s2 * den2_s2;

		ratio.neg <= num_s3[63];
		ratio.mag <= num_s3[63] ? 63'(-num_s3) : num_s3[62:0];
		ratio.bad <= den_s3[63] || (den_s3 == '0);
		ratio.den <= den_s3[DIV_W-1:0];
	end

	assign done = v_q[3];

endmodule

`default_nettype wire

FILE: rtl/core/swm_divider.sv
// ----------------------------------------------------------------------------
// SSIM restoring divider
// Shared radix-2 divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_divider import swm_pkg::*; #(
	parameter int QB = 17
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] rem_init,
	input  wire logic [QB-1:0]    low_bits,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  busy,
	output logic                  done,
	output logic [QB-1:0]         quotient
);

	localparam int CNTW = $clog2(QB + 1);

	logic [CNTW-1:0]  cnt_q;
	logic             busy_q, done_q;
	logic [DIV_W-1:0] rem_q, div_q;
	logic [QB-1:0]    bits_q, quo_q;
	logic [DIV_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, bits_q[QB-1]};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= rem_init;
			bits_q <= low_bits;
			div_q  <= divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? DIV_W'(trial - {1'b0, div_q}) : trial[DIV_W-1:0];
			bits_q <= bits_q << 1;
			quo_q  <= {quo_q[QB-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: rtl/core/ssim_window_metric.sv
// ----------------------------------------------------------------------------
// SSIM window metric
// Streaming integer SSIM over 8x8 windows on a 4-pixel grid, with frame mean.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Word
//   in_*      input      in_valid / in_ready    swm_pixel_t (src, ref pixel)
//   out_*     output     out_valid / out_ready  swm_result_t (one result)
//   APB       input      psel, penable, pwrite  frame_width at 0, height at 4
//
// A pixel that ends no window passes through the accept cycle, which reads
// the block's sums, and the update cycle, which writes them back. A pixel that
// ends a window adds a gather step, the multiplier pipeline and the serial
// divider, which yields FRACTION_BITS+1 quotient bits; the frame's last pixel
// adds a further division for the mean. Reset clears the position, the total,
// the tally and the output valid and sets both sizes to 8: the block stores
// need no clearing pass. A result waiting on out_ready holds the next pixel
// only when a new result must be loaded.
//
`default_nettype none

module ssim_window_metric import swm_pkg::*; #(
	parameter int MAX_WIDTH     = 4096,
	parameter int MAX_HEIGHT    = 4096,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire swm_pixel_t  in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output swm_result_t      out_data,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int BLOCK_COLS = MAX_WIDTH / 4;
	localparam int AW   = $clog2(BLOCK_COLS);
	localparam int CW   = $clog2(MAX_WIDTH);
	localparam int RHW  = $clog2(MAX_HEIGHT);
	localparam int WW   = $clog2(MAX_WIDTH + 1);
	localparam int HW   = $clog2(MAX_HEIGHT + 1);
	localparam int TW   = $clog2((MAX_WIDTH / 4) * (MAX_HEIGHT / 4) + 1);
	localparam int QB   = FRACTION_BITS + 1;
	localparam int VW   = FRACTION_BITS + 2;
	localparam int TOTW = FRACTION_BITS + TW + 2;

	// Configuration registers.
	logic [12:0] fw_q, fh_q;

	// Stream position and per-frame totals.
	logic [CW-1:0]          col_q;
	logic [RHW-1:0]         row_q;
	logic signed [TOTW-1:0] total_q;
	logic [TW-1:0]          tally_q;

	swm_state_t state_q, state_d;

	// The pixel being worked on.
	swm_pixel_t  pix_q;
	logic [AW-1:0] bc_q;
	logic        first_q, win_q, fend_q;
	logic [11:0] winx_q, winy_q;
	swm_block_t  cur_new_q, prev_bc_q;
	logic        neg_q, bad_q, mean_neg_q, mean_zero_q;

	// Output register.
	logic        out_valid_q;
	swm_result_t out_q;

	// Position decode for the pixel at the input.
	logic [WW-1:0]   w_eff;
	logic [HW-1:0]   h_eff;
	logic            col_last, row_last, fend_now, win_now, first_now, in_range_now;
	logic [CW-3:0]   bc_full;
	logic            accept;

	// Control outputs of the sequencer.
	logic          rd_en, upd_en, calc_start, div_start, load_win, load_mean, out_free;
	logic [AW-1:0] rd_addr;

	swm_block_t cur_rdata, prev_rdata, cur_new;
	swm_sums_t  sums;
	logic       calc_done;
	swm_ratio_t ratio;

	logic [DIV_W-1:0] div_rem, div_divisor;
	logic [QB-1:0]    div_low, quotient;
	logic             div_busy, div_done;

	logic [TOTW-1:0]        total_mag;
	logic signed [VW-1:0]   q_ext, win_val, mean_val;

	function automatic swm_sums_t add_blocks(swm_block_t a, swm_block_t b,
	                                         swm_block_t c, swm_block_t d);
		swm_sums_t t;
		t.s  = 14'(a.pixel_sums[11:0]) + 14'(b.pixel_sums[11:0])
			+ 14'(c.pixel_sums[11:0]) + 14'(d.pixel_sums[11:0]);
		t.r  = 14'(a.pixel_sums[23:12]) + 14'(b.pixel_sums[23:12])
			+ 14'(c.pixel_sums[23:12]) + 14'(d.pixel_sums[23:12]);
		t.ss = 22'(a.square_sums[19:0]) + 22'(b.square_sums[19:0])
			+ 22'(c.square_sums[19:0]) + 22'(d.square_sums[19:0]);
		t.rr = 22'(a.square_sums[39:20]) + 22'(b.square_sums[39:20])
			+ 22'(c.square_sums[39:20]) + 22'(d.square_sums[39:20]);
		t.sr = 22'(a.square_sums[59:40]) + 22'(b.square_sums[59:40])
			+ 22'(c.square_sums[59:40]) + 22'(d.square_sums[59:40]);
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Configuration port. Writes take effect on the access cycle; reads
	// return the stored value. Address bit 2 picks the register.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= 13'd8;
			fh_q <= 13'd8;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_FRAME_WIDTH:  fw_q <= pwdata[12:0];
				REG_FRAME_HEIGHT: fh_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FRAME_WIDTH:  prdata = {19'd0, fw_q};
			REG_FRAME_HEIGHT: prdata = {19'd0, fh_q};
			default:          prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Position decode. Sizes out of range are clamped; a row ends when the
	// column is at or past the last column, which also covers a size that
	// has shrunk under a running frame.
	// ------------------------------------------------------------------
	always_comb begin
		if (fw_q == 13'd0) begin
			w_eff = WW'(1);
		end else if (32'(fw_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(fw_q);
		end
		if (fh_q == 13'd0) begin
			h_eff = HW'(1);
		end else if (32'(fh_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(fh_q);
		end
	end

	assign col_last     = WW'(col_q) >= (w_eff - WW'(1));
	assign row_last     = HW'(row_q) >= (h_eff - HW'(1));
	assign fend_now     = col_last && row_last;
	assign first_now    = (col_q[1:0] == 2'd0) && (row_q[1:0] == 2'd0);
	assign win_now      = (col_q[1:0] == 2'd3) && (row_q[1:0] == 2'd3)
		&& (col_q >= CW'(7)) && (row_q >= RHW'(7));
	assign bc_full      = col_q[CW-1:2];
	assign in_range_now = {1'b0, bc_full} < (CW-1)'(BLOCK_COLS);
	assign accept       = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + RHW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q   <= in_data;
			bc_q    <= bc_full[AW-1:0];
			first_q <= first_now;
			win_q   <= win_now;
			fend_q  <= fend_now;
			winx_q  <= 12'(col_q - CW'(7));
			winy_q  <= 12'(row_q - RHW'(7));
		end
		if (upd_en) begin
			cur_new_q <= cur_new;
			prev_bc_q <= prev_rdata;
		end
		if (calc_done) begin
			neg_q <= ratio.neg;
			bad_q <= ratio.bad;
		end
		if (state_q == ST_MEAN_START) begin
			mean_neg_q  <= total_q[TOTW-1];
			mean_zero_q <= (tally_q == '0);
		end
	end

	// ------------------------------------------------------------------
	// Sequencer. One pixel is in flight at a time: its read-modify-write
	// of the block store finishes before the next pixel's read is issued,
	// so no forwarding path is needed.
	// ------------------------------------------------------------------
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_range_now) begin
						state_d = ST_UPDATE;
					end else if (fend_now) begin
						state_d = ST_MEAN_START;
					end
				end
			end
			ST_UPDATE: begin
				if (win_q) begin
					state_d = ST_GATHER;
				end else if (fend_q) begin
					state_d = ST_MEAN_START;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_GATHER: state_d = ST_CALC;
			ST_CALC: begin
				if (calc_done) begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_WIN_OUT;
				end
			end
			ST_WIN_OUT: begin
				if (out_free) begin
					state_d = fend_q ? ST_MEAN_START : ST_IDLE;
				end
			end
			ST_MEAN_START: state_d = ST_MEAN_DIV;
			ST_MEAN_DIV: begin
				if (div_done) begin
					state_d = ST_MEAN_OUT;
				end
			end
			ST_MEAN_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = bc_full[AW-1:0];
		upd_en     = 1'b0;
		calc_start = 1'b0;
		div_start  = 1'b0;
		load_win   = 1'b0;
		load_mean  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid && in_range_now;
			end
			ST_UPDATE: begin
				upd_en  = 1'b1;
				rd_en   = win_q;
				rd_addr = bc_q - AW'(1);
			end
			ST_GATHER:     calc_start = 1'b1;
			ST_CALC:       div_start  = calc_done;
			ST_WIN_OUT:    load_win   = out_free;
			ST_MEAN_START: div_start  = 1'b1;
			ST_MEAN_OUT:   load_mean  = out_free;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath units.
	// ------------------------------------------------------------------
	swm_block_store #(
		.DEPTH (BLOCK_COLS),
		.AW    (AW)
	) u_store (
		.clk        (clk),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.upd_en     (upd_en),
		.upd_first  (first_q),
		.upd_addr   (bc_q),
		.pix        (pix_q),
		.cur_rdata  (cur_rdata),
		.prev_rdata (prev_rdata),
		.cur_new    (cur_new)
	);

	// Upper-left and upper-right come from the previous block row, the left
	// block from the current row, and the lower-right block is the one just
	// updated.
	assign sums = add_blocks(prev_rdata, prev_bc_q, cur_rdata, cur_new_q);

	swm_window_calc u_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (calc_start),
		.sums   (sums),
		.done   (calc_done),
		.ratio  (ratio)
	);

	// The window quotient is at most one, so the division starts from half
	// the numerator and shifts in its last bit and the fraction zeros. The
	// mean is at most one in magnitude too, which bounds its quotient alike.
	assign total_mag = total_q[TOTW-1] ? TOTW'(-total_q) : TOTW'(total_q);

	always_comb begin
		if (state_q == ST_MEAN_START) begin
			div_rem     = DIV_W'(total_mag >> QB);
			div_low     = total_mag[QB-1:0];
			div_divisor = DIV_W'(tally_q);
		end else begin
			div_rem     = DIV_W'(ratio.mag >> 1);
			div_low     = {ratio.mag[0], (QB-1)'(0)};
			div_divisor = ratio.den;
		end
	end

	swm_divider #(
		.QB (QB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem),
		.low_bits (div_low),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign q_ext    = {1'b0, quotient};
	assign win_val  = bad_q ? '0 : (neg_q ? -q_ext : q_ext);
	assign mean_val = mean_zero_q ? '0 : (mean_neg_q ? -q_ext : q_ext);

	// ------------------------------------------------------------------
	// Totals and the output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			tally_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_win) begin
				total_q <= total_q + TOTW'(win_val);
				tally_q <= tally_q + TW'(1);
			end else if (load_mean) begin
				total_q <= '0;
				tally_q <= '0;
			end
			if (load_win || load_mean) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_win) begin
			out_q.is_frame_mean  <= 1'b0;
			out_q.window_x       <= winx_q;
			out_q.window_y       <= winy_q;
			out_q.ssim_value     <= 18'(win_val);
			out_q.windows_so_far <= 20'(tally_q + TW'(1));
			out_q.last_of_item   <= !fend_q;
		end else if (load_mean) begin
			out_q.is_frame_mean  <= 1'b1;
			out_q.window_x       <= '0;
			out_q.window_y       <= '0;
			out_q.ssim_value     <= 18'(mean_val);
			out_q.windows_so_far <= 20'(tally_q);
			out_q.last_of_item   <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef SYNTH
	// The shared divider is never restarted while a division runs.
	a_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// A block update always uses read data requested in the cycle before.
	a_upd_read: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en |-> $past(rd_en))
		else $error("block update without a preceding read");

	// A window on the frame's last pixel is followed by the frame mean.
	a_mean_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(load_win && fend_q) |=> (state_q == ST_MEAN_START))
		else $error("frame mean not started after last window");
`endif

endmodule

`default_nettype wire
